// File: hw/rtl/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

    localparam int DEPTH   = 16;
    localparam int KEY_W   = 16;
    localparam int TAG_W   = 8;
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int FILL_W  = 5;
    localparam int STAT_W  = 2;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 2'd0,
        ST_EMPTY      = 2'd1,
        ST_FULL       = 2'd2,
        ST_UNUSED     = 2'd3
    } status_t;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } entry_t;

    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } cmd_t;

endpackage

// File: hw/rtl/spq_cell.sv
`timescale 1ns / 1ps

module spq_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  spq_pkg::cmd_t  cmd,
    input  logic           left_take,
    input  spq_pkg::entry_t left_entry,
    input  spq_pkg::entry_t right_entry,
    output logic           take,
    output spq_pkg::entry_t entry
);

    logic                      valid_reg;
    logic                      valid_next;
    logic [spq_pkg::KEY_W-1:0] key_reg;
    logic [spq_pkg::KEY_W-1:0] key_next;
    logic [spq_pkg::TAG_W-1:0] tag_reg;
    logic [spq_pkg::TAG_W-1:0] tag_next;

    assign take  = !valid_reg || (cmd.key <= key_reg);
    assign entry = '{valid: valid_reg, key: key_reg, tag: tag_reg};

    always_comb begin
        valid_next = valid_reg;
        key_next   = key_reg;
        tag_next   = tag_reg;
        priority if (cmd.ins && left_take) begin
            valid_next = left_entry.valid;
            key_next   = left_entry.key;
            tag_next   = left_entry.tag;
        end else if (cmd.ins && take) begin
            valid_next = 1'b1;
            key_next   = cmd.key;
            tag_next   = cmd.tag;
        end else if (cmd.rem) begin
            valid_next = right_entry.valid;
            key_next   = right_entry.key;
            tag_next   = right_entry.tag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

endmodule

// File: hw/rtl/sorted_priority_queue_unit.sv
`timescale 1ns / 1ps
// Sorted priority queue, entries kept in ascending key order in a row of cells.
// Input channel s_*: one word per operation. s_tuser is the op (insert or
// remove), s_tdata carries key and tag for an insert. Insert places the entry
// ahead of any held entry with an equal or larger key; remove pops the smallest.
// Result channel m_*: exactly one word per accepted input word, carrying the
// removed key and tag (zero for inserts and failed removes), the fill count
// after the operation, and a status in m_tuser (ok, remove on empty, insert on
// full). A full insert is dropped.
// Latency: result is valid the cycle after the input word is accepted.
// Throughput: one word per cycle while the receiver keeps m_tready high; every cell
// compares its key against the broadcast key and shifts toward its neighbor as the word is accepted.
// Stall: a held result blocks new input only while m_tready is low; when the
// receiver takes the result, a new word is accepted in the same cycle.
// Reset (aresetn low, synchronous): the queue is emptied and m_tvalid drops.
module sorted_priority_queue_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [spq_pkg::S_DATA_W-1:0] s_tdata,   // key[15:0], tag[23:16]
    input  logic                         s_tuser,   // op[0]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [spq_pkg::M_DATA_W-1:0] m_tdata,   // out_key[15:0], out_tag[23:16], fill[28:24]
    output logic [spq_pkg::STAT_W-1:0]   m_tuser    // status[1:0]
);

    localparam int D  = spq_pkg::DEPTH;
    localparam int CW = spq_pkg::COUNT_W;
    localparam int FW = spq_pkg::FILL_W;

    spq_pkg::cmd_t             cmd;
    spq_pkg::entry_t           entries [D];
    spq_pkg::entry_t           right_in [D];
    logic                      take_vec [D];
    logic                      left_take [D];
    logic [D-1:0]              valid_vec;
    logic                      fire;
    logic                      is_remove;
    logic                      full;
    logic                      empty;

    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic                      m_valid_reg;
    logic [spq_pkg::KEY_W-1:0] m_key_reg;
    logic [spq_pkg::KEY_W-1:0] m_key_next;
    logic [spq_pkg::TAG_W-1:0] m_tag_reg;
    logic [spq_pkg::TAG_W-1:0] m_tag_next;
    spq_pkg::status_t          m_stat_reg;
    spq_pkg::status_t          m_stat_next;
    logic [FW+CW-1:0]          fill_ext;

    assign s_tready  = !m_valid_reg || m_tready;
    assign fire      = s_tvalid && s_tready;
    assign is_remove = (s_tuser == spq_pkg::OP_REMOVE);
    assign full      = (count_reg == CW'(D));
    assign empty     = (count_reg == '0);

    assign cmd.ins = fire && !is_remove && !full;
    assign cmd.rem = fire && is_remove && !empty;
    assign cmd.key = s_tdata[spq_pkg::KEY_W-1:0];
    assign cmd.tag = s_tdata[spq_pkg::KEY_W +: spq_pkg::TAG_W];

    for (genvar i = 0; i < D; i++) begin : g_cell
        if (i == 0) begin : g_first
            assign left_take[i] = 1'b0;
        end else begin : g_rest
            assign left_take[i] = take_vec[i-1];
        end
        if (i == D - 1) begin : g_last
            assign right_in[i] = '0;
        end else begin : g_inner
            assign right_in[i] = entries[i+1];
        end
        assign valid_vec[i] = entries[i].valid;

        spq_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmd         (cmd),
            .left_take   (left_take[i]),
            .left_entry  (i == 0 ? '0 : entries[(i == 0) ? 0 : i-1]),
            .right_entry (right_in[i]),
            .take        (take_vec[i]),
            .entry       (entries[i])
        );
    end

    always_comb begin
        count_next  = count_reg;
        m_key_next  = '0;
        m_tag_next  = '0;
        m_stat_next = spq_pkg::ST_OK;
        if (is_remove) begin
            if (empty) begin
                m_stat_next = spq_pkg::ST_EMPTY;
            end else begin
                m_key_next = entries[0].key;
                m_tag_next = entries[0].tag;
                count_next = count_reg - CW'(1);
            end
        end else begin
            if (full) begin
                m_stat_next = spq_pkg::ST_FULL;
            end else begin
                count_next = count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                count_reg <= count_next;
            end
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_key_reg  <= m_key_next;
            m_tag_reg  <= m_tag_next;
            m_stat_reg <= m_stat_next;
        end
    end

    assign fill_ext = {{FW{1'b0}}, count_reg};
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_stat_reg;
    assign m_tdata  = {{(spq_pkg::M_DATA_W - FW - spq_pkg::TAG_W - spq_pkg::KEY_W){1'b0}},
                       fill_ext[FW-1:0], m_tag_reg, m_key_reg};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(D))
        else $error("count exceeds depth");

    a_valid_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == int'(count_reg))
        else $error("cell valid bits disagree with count");

    a_remove_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && is_remove && !empty) |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("remove did not shrink queue");

    a_fail_zero_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_stat_reg != spq_pkg::ST_OK) |-> (m_key_reg == '0 && m_tag_reg == '0))
        else $error("failed operation returned payload");
`endif

endmodule

// File: tb/sorted_priority_queue_unit_test.sv
`timescale 1ns / 1ps

module sorted_priority_queue_unit_test;

    localparam int STALL_LIMIT = 2000;

    typedef struct {
        spq_pkg::op_t              op;
        logic [spq_pkg::KEY_W-1:0] key;
        logic [spq_pkg::TAG_W-1:0] tag;
    } queue_op_t;

    typedef struct {
        logic [spq_pkg::KEY_W-1:0]  key;
        logic [spq_pkg::TAG_W-1:0]  tag;
        spq_pkg::status_t           status;
        logic [spq_pkg::FILL_W-1:0] fill;
    } queue_result_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [spq_pkg::S_DATA_W-1:0]   s_tdata = '0;   // key[15:0], tag[23:16]
    logic                           s_tuser = 1'b0; // op[0]
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [spq_pkg::M_DATA_W-1:0]   m_tdata;        // out_key[15:0], out_tag[23:16], fill[28:24]
    logic [spq_pkg::STAT_W-1:0]     m_tuser;        // status[1:0]

    queue_op_t                 ops_to_send[$];
    queue_result_t             results_due[$];
    logic [spq_pkg::KEY_W-1:0] held_keys[spq_pkg::DEPTH];
    logic [spq_pkg::TAG_W-1:0] held_tags[spq_pkg::DEPTH];
    int              held_count = 0;
    int              words_queued = 0;
    int              words_sent = 0;
    int              error_count = 0;
    int              send_idle_pct = 0;
    int              recv_stall_pct = 0;
    int              stall_cycles = 0;
    logic            in_taken = 1'b0;

    sorted_priority_queue_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic queue_result_t sorted_queue_apply(spq_pkg::op_t op,
                                                         logic [spq_pkg::KEY_W-1:0] key,
                                                         logic [spq_pkg::TAG_W-1:0] tag);
        queue_result_t r;
        int pos;
        int i;
        r.key = '0;
        r.tag = '0;
        r.status = spq_pkg::ST_OK;
        if (op == spq_pkg::OP_INSERT) begin
            if (held_count >= spq_pkg::DEPTH) begin
                r.status = spq_pkg::ST_FULL;
            end else begin
                pos = held_count;
                for (i = held_count - 1; i >= 0; i--)
                    if (key <= held_keys[i])
                        pos = i;
                for (i = held_count; i > pos; i--) begin
                    held_keys[i] = held_keys[i-1];
                    held_tags[i] = held_tags[i-1];
                end
                held_keys[pos] = key;
                held_tags[pos] = tag;
                held_count++;
            end
        end else begin
            if (held_count == 0) begin
                r.status = spq_pkg::ST_EMPTY;
            end else begin
                r.key = held_keys[0];
                r.tag = held_tags[0];
                for (i = 1; i < held_count; i++) begin
                    held_keys[i-1] = held_keys[i];
                    held_tags[i-1] = held_tags[i];
                end
                held_count--;
                held_keys[held_count] = '0;
                held_tags[held_count] = '0;
            end
        end
        r.fill = spq_pkg::FILL_W'(held_count);
        return r;
    endfunction

    task automatic push_op(spq_pkg::op_t op, logic [spq_pkg::KEY_W-1:0] key,
                           logic [spq_pkg::TAG_W-1:0] tag);
        queue_op_t w;
        w.op = op;
        w.key = key;
        w.tag = tag;
        ops_to_send.push_back(w);
        words_queued++;
    endtask

    task automatic wait_drained();
        do
            @(negedge aclk);
        while (words_sent != words_queued || results_due.size() != 0);
    endtask

    // Bursts with a random insert or remove bias walk the fill level between empty and full.
    task automatic run_phase(int send_pct, int recv_pct, int count);
        int left;
        int burst;
        int ins_pct;
        int key_mode;
        logic [spq_pkg::KEY_W-1:0] k;
        @(posedge aclk);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(40, 8);
            case ($urandom_range(3))
                0: ins_pct = 15;
                1: ins_pct = 50;
                default: ins_pct = 85;
            endcase
            key_mode = $urandom_range(3);
            for (int n = 0; n < burst && left > 0; n++) begin
                case (key_mode)
                    0: k = spq_pkg::KEY_W'($urandom_range(7));
                    1: k = spq_pkg::KEY_W'($urandom_range(65535, 65528));
                    default: k = spq_pkg::KEY_W'($urandom);
                endcase
                push_op(($urandom_range(99) < ins_pct) ? spq_pkg::OP_INSERT
                                                       : spq_pkg::OP_REMOVE,
                        k, spq_pkg::TAG_W'($urandom));
                left--;
            end
        end
        wait_drained();
    endtask

    // Hold the word until taken; pick the next one only after a handshake.
    always @(negedge aclk) begin : feed
        queue_op_t nx;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (ops_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nx = ops_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {nx.tag, nx.key};
                s_tuser <= nx.op;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin : watch
        queue_result_t exp_r;
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected result word, got %h / %h", $time, m_tdata, m_tuser);
                    error_count++;
                end else begin
                    exp_r = results_due.pop_front();
                    if (m_tdata[15:0] !== exp_r.key) begin
                        $display("%0t: out_key expected %h got %h", $time, exp_r.key,
                                 m_tdata[15:0]);
                        error_count++;
                    end
                    if (m_tdata[23:16] !== exp_r.tag) begin
                        $display("%0t: out_tag expected %h got %h", $time, exp_r.tag,
                                 m_tdata[23:16]);
                        error_count++;
                    end
                    if (m_tdata[28:24] !== exp_r.fill) begin
                        $display("%0t: fill expected %0d got %0d", $time, exp_r.fill,
                                 m_tdata[28:24]);
                        error_count++;
                    end
                    if (m_tuser !== exp_r.status) begin
                        $display("%0t: status expected %0d got %0d", $time, exp_r.status,
                                 m_tuser);
                        error_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                results_due.push_back(sorted_queue_apply(spq_pkg::op_t'(s_tuser),
                                                         s_tdata[15:0], s_tdata[23:16]));
                words_sent++;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("sorted_priority_queue_unit_test: errors");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < spq_pkg::DEPTH; i++) begin
            held_keys[i] = '0;
            held_tags[i] = '0;
        end
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // remove on empty, then fill with extremes and equal keys, then insert on full, then remove five
        push_op(spq_pkg::OP_REMOVE, 16'hFFFF, 8'hFF);
        push_op(spq_pkg::OP_INSERT, 16'hFFFF, 8'hFF);
        push_op(spq_pkg::OP_INSERT, 16'h0000, 8'h00);
        push_op(spq_pkg::OP_INSERT, 16'h8000, 8'h01);
        push_op(spq_pkg::OP_INSERT, 16'h8000, 8'h02);
        push_op(spq_pkg::OP_INSERT, 16'h8000, 8'h03);
        push_op(spq_pkg::OP_INSERT, 16'hFFFF, 8'h04);
        push_op(spq_pkg::OP_INSERT, 16'h0001, 8'h05);
        for (int i = 0; i < spq_pkg::DEPTH - 7; i++)
            push_op(spq_pkg::OP_INSERT,
                    spq_pkg::KEY_W'(16'h1000 * (spq_pkg::DEPTH - 7 - i)),
                    spq_pkg::TAG_W'(8'h10 + i));
        push_op(spq_pkg::OP_INSERT, 16'h0000, 8'hAA);
        repeat (5)
            push_op(spq_pkg::OP_REMOVE, 16'h0000, 8'h00);
        wait_drained();

        run_phase(0, 0, 250);
        run_phase(58, 0, 220);
        run_phase(0, 58, 220);
        run_phase(20, 20, 220);
        run_phase(0, 0, 190);
        repeat (8) @(posedge aclk);

        if (error_count == 0)
            $display("sorted_priority_queue_unit_test: clean");
        else
            $display("sorted_priority_queue_unit_test: errors");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue_unit.sv
tb/sorted_priority_queue_unit_test.sv
